@@ rtl/core/ita_pkg.sv @@
// Shared types, format codes and ASCII constants for the integer-to-ASCII formatter.
// No dependencies; every other file but ita_if.sv imports this package.
package ita_pkg;

    localparam int NUM_CELLS  = 16;   // one cell per hex digit of a 64-bit pointer
    localparam int CONV_BITS  = 32;   // bits shifted through the BCD chain for decimal
    localparam int NDIG_W     = $clog2(NUM_CELLS + 1);
    localparam int BIT_CNT_W  = $clog2(CONV_BITS);

    localparam logic [2:0] FMT_SDEC = 3'd0;
    localparam logic [2:0] FMT_UDEC = 3'd1;
    localparam logic [2:0] FMT_HEXL = 3'd2;
    localparam logic [2:0] FMT_HEXU = 3'd3;
    localparam logic [2:0] FMT_PTR  = 3'd4;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;
    localparam logic [7:0] ASCII_X     = 8'h78;
    localparam logic [7:0] ASCII_LA    = 8'h61;  // 'a'
    localparam logic [7:0] ASCII_UA    = 8'h41;  // 'A'

    typedef struct packed {
        logic load;    // take a parallel nibble
        logic dabble;  // add-3 correction and shift one bit in from below
        logic shift;   // take the digit of the cell below
    } t_cell_ctrl;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? ASCII_UA : ASCII_LA;
            if (d < 4'd10) begin
                digit_char = ASCII_ZERO + {4'd0, d};
            end else begin
                digit_char = base + {4'd0, d - 4'd10};
            end
        end
    endfunction

endpackage

@@ rtl/core/ita_if.sv @@
// Valid/ready channel interfaces for the formatter's input items and output characters.
// Depends on nothing.
interface ita_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [2:0]  req_type;

    modport source (output valid, output value, output req_type, input ready);
    modport sink   (input valid, input value, input req_type, output ready);
endinterface

interface ita_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       is_last;
    logic [4:0] char_count;

    modport source (output valid, output char_out, output is_last, output char_count,
                    input ready);
    modport sink   (input valid, input char_out, input is_last, input char_count,
                    output ready);
endinterface

@@ rtl/core/ita_cell.sv @@
// One digit cell: a 4-bit BCD/hex digit with double-dabble step, load and shift-up.
// Depends on ita_pkg.
module ita_cell
    import ita_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic [3:0] i_load_digit,
    input  logic       i_lower_bit,
    input  logic [3:0] i_lower_digit,
    output logic [3:0] o_digit,
    output logic       o_carry
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] adj;

    assign adj     = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = adj[3];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.load) begin
            n_digit = i_load_digit;
        end else if (i_ctrl.dabble) begin
            n_digit = {adj[2:0], i_lower_bit};
        end else if (i_ctrl.shift) begin
            n_digit = i_lower_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

@@ rtl/core/ita_chain.sv @@
// Row of digit cells: bits enter cell 0, digits move toward the top cell.
// Depends on ita_pkg and ita_cell.
module ita_chain
    import ita_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic [NUM_CELLS*4-1:0]   i_load,
    input  logic                     i_bit,
    output logic [3:0]               o_top
);

    logic [3:0] digit [NUM_CELLS];
    logic       carry [NUM_CELLS];

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        logic       lower_bit;
        logic [3:0] lower_digit;
        if (g == 0) begin : g_first
            assign lower_bit   = i_bit;
            assign lower_digit = 4'd0;
        end else begin : g_rest
            assign lower_bit   = carry[g-1];
            assign lower_digit = digit[g-1];
        end
        ita_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_load_digit (i_load[g*4 +: 4]),
            .i_lower_bit  (lower_bit),
            .i_lower_digit(lower_digit),
            .o_digit      (digit[g]),
            .o_carry      (carry[g])
        );
    end

    assign o_top = digit[NUM_CELLS-1];

endmodule

@@ rtl/core/integer_to_ascii_formatter.sv @@
// Integer-to-ASCII formatter: decimal, hex and pointer text, one character per transfer.
// A decimal item first passes through the BCD cell chain, a hex or pointer item is loaded
// directly; then leading zeros are dropped, then one character per cycle while the sink is ready.
// One item at a time: a new item is accepted only in idle, once the previous item's last
// character has been issued.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
module integer_to_ascii_formatter
    import ita_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ita_in_if.sink     i_in,
    ita_out_if.source  o_out
);

    t_state                 r_state, n_state;
    logic [CONV_BITS-1:0]   r_mag;
    logic [BIT_CNT_W-1:0]   r_bit;
    logic [NDIG_W-1:0]      r_ndig;
    logic [1:0]             r_pre_len;
    logic [1:0]             r_pre_pos;
    logic                   r_ptr;
    logic                   r_upper;
    logic [4:0]             r_cnt;
    logic                   r_out_valid;
    logic [7:0]             r_char;
    logic                   r_last;
    logic [4:0]             r_count;

    t_cell_ctrl             ctrl;
    logic [NUM_CELLS*4-1:0] load_vec;
    logic [3:0]             top;
    logic                   accept;
    logic                   take;
    logic                   in_prefix;
    logic                   skip_more;
    logic [31:0]            lo;
    logic                   neg;
    logic                   fmt_ok;

    assign lo     = i_in.value[31:0];
    assign neg    = (i_in.req_type == FMT_SDEC) && lo[31];
    assign fmt_ok = (i_in.req_type == FMT_SDEC) || (i_in.req_type == FMT_UDEC) ||
                    (i_in.req_type == FMT_HEXL) || (i_in.req_type == FMT_HEXU) ||
                    (i_in.req_type == FMT_PTR);

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign take       = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign in_prefix  = (r_pre_pos != r_pre_len);
    assign skip_more  = (top == 4'd0) && (r_ndig > NDIG_W'(1));

    always_comb begin
        case (i_in.req_type)
            FMT_PTR:  load_vec = i_in.value;
            FMT_HEXL,
            FMT_HEXU: load_vec = {32'd0, lo};
            default:  load_vec = '0;
        endcase
    end

    always_comb begin
        ctrl.load   = accept;
        ctrl.dabble = (r_state == S_CONV);
        ctrl.shift  = ((r_state == S_SKIP) && skip_more) || (take && !in_prefix);
    end

    ita_chain u_chain (
        .i_clk (i_clk),
        .i_ctrl(ctrl),
        .i_load(load_vec),
        .i_bit (r_mag[CONV_BITS-1]),
        .o_top (top)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && fmt_ok) begin
                    if (i_in.req_type == FMT_SDEC || i_in.req_type == FMT_UDEC) begin
                        n_state = S_CONV;
                    end else begin
                        n_state = S_SKIP;
                    end
                end
            end
            S_CONV: begin
                if (r_bit == '0) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (!skip_more) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (take && !in_prefix && r_ndig == NDIG_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag     <= neg ? (32'd0 - lo) : lo;
            r_bit     <= BIT_CNT_W'(CONV_BITS - 1);
            r_ndig    <= NDIG_W'(NUM_CELLS);
            r_pre_len <= (i_in.req_type == FMT_PTR) ? 2'd2 : (neg ? 2'd1 : 2'd0);
            r_pre_pos <= 2'd0;
            r_ptr     <= (i_in.req_type == FMT_PTR);
            r_upper   <= (i_in.req_type == FMT_HEXU);
        end
        if (r_state == S_CONV) begin
            r_mag <= {r_mag[CONV_BITS-2:0], 1'b0};
            r_bit <= r_bit - BIT_CNT_W'(1);
        end
        if (r_state == S_SKIP) begin
            if (skip_more) begin
                r_ndig <= r_ndig - NDIG_W'(1);
            end else begin
                r_cnt <= {3'd0, r_pre_len} + 5'(r_ndig);
            end
        end
        if (take) begin
            if (in_prefix) begin
                r_pre_pos <= r_pre_pos + 2'd1;
                if (r_ptr) begin
                    r_char <= (r_pre_pos == 2'd0) ? ASCII_ZERO : ASCII_X;
                end else begin
                    r_char <= ASCII_MINUS;
                end
                r_last  <= 1'b0;
                r_count <= 5'd0;
            end else begin
                r_ndig  <= r_ndig - NDIG_W'(1);
                r_char  <= digit_char(top, r_upper);
                r_last  <= (r_ndig == NDIG_W'(1));
                r_count <= (r_ndig == NDIG_W'(1)) ? r_cnt : 5'd0;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.char_out   = r_char;
    assign o_out.is_last    = r_last;
    assign o_out.char_count = r_count;

    a_conv_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) && (r_bit == '0) |=> (r_state == S_SKIP))
        else $error("conversion did not hand over to zero skip");

    a_ndig_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) || (r_state == S_SKIP) |-> (r_ndig != '0))
        else $error("digit count ran out before the last character");

    a_count_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_last |-> (o_out.char_count == 5'd0))
        else $error("character count shown on a non-final character");

    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !in_prefix && (r_ndig == NDIG_W'(1)) |=> (r_state == S_IDLE) && r_last)
        else $error("final character not flagged");

endmodule

@@ test/ita_text_checker.sv @@
// Checker for the integer-to-ASCII formatter: watches both channels, builds the expected text
// of every accepted item and compares each output character with it.
// Depends on ita_pkg for the format codes and ASCII constants.
module ita_text_checker
    import ita_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_value,
    input  logic [2:0]  i_in_req_type,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_char,
    input  logic        i_out_is_last,
    input  logic [4:0]  i_out_char_count,
    output int          o_error_count,
    output int          o_pending,
    output int          o_chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] glyph;
        logic       last;
        logic [4:0] count;
    } text_char_t;

    text_char_t expected_text[$];
    int         error_total   = 0;
    int         chars_checked = 0;
    int         pending_chars = 0;

    assign o_error_count   = error_total;
    assign o_pending       = pending_chars;
    assign o_chars_checked = chars_checked;

    // Append the characters that one item should produce, most significant digit first.
    function automatic void queue_expected_text(input logic [63:0] value,
                                                input logic [2:0] fmt);
        logic [7:0]  text [0:19];
        logic [7:0]  rev  [0:19];
        logic [63:0] mag;
        logic [63:0] radix;
        logic [31:0] neg;
        logic [3:0]  digit;
        logic        upper;
        int          len;
        int          ndig;
        text_char_t  entry;

        len   = 0;
        ndig  = 0;
        upper = 1'b0;
        radix = 64'd10;
        mag   = {32'd0, value[31:0]};
        case (fmt)
            FMT_SDEC: begin
                if (value[31]) begin
                    text[len] = ASCII_MINUS;
                    len++;
                    neg = 32'd0 - value[31:0];
                    mag = {32'd0, neg};
                end
            end
            FMT_UDEC: begin
            end
            FMT_HEXL: begin
                radix = 64'd16;
            end
            FMT_HEXU: begin
                radix = 64'd16;
                upper = 1'b1;
            end
            FMT_PTR: begin
                text[0] = ASCII_ZERO;
                text[1] = ASCII_X;
                len     = 2;
                radix   = 64'd16;
                mag     = value;
            end
            default: begin
                // unused selectors produce no text
                return;
            end
        endcase

        // zero still yields one digit
        do begin
            digit = 4'(mag % radix);
            if (digit < 4'd10) begin
                rev[ndig] = ASCII_ZERO + 8'(digit);
            end else begin
                rev[ndig] = (upper ? ASCII_UA : ASCII_LA) + 8'(digit) - 8'd10;
            end
            ndig++;
            mag = mag / radix;
        end while (mag != 64'd0);

        for (int k = ndig - 1; k >= 0; k--) begin
            text[len] = rev[k];
            len++;
        end

        for (int k = 0; k < len; k++) begin
            entry.glyph = text[k];
            entry.last  = (k == len - 1);
            entry.count = (k == len - 1) ? 5'(len) : 5'd0;
            expected_text.push_back(entry);
        end
    endfunction

    always @(posedge i_clk) begin
        text_char_t want;
        if (!i_rst_n) begin
            expected_text.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                queue_expected_text(i_in_value, i_in_req_type);
            end
            if (i_out_valid && i_out_ready) begin
                chars_checked++;
                if (expected_text.size() == 0) begin
                    $error("unexpected character transfer: char_out 8'h%02h is_last %0b",
                           i_out_char, i_out_is_last);
                    error_total++;
                end else begin
                    want = expected_text.pop_front();
                    if (i_out_char !== want.glyph) begin
                        $error("char_out: expected 8'h%02h, got 8'h%02h",
                               want.glyph, i_out_char);
                        error_total++;
                    end
                    if (i_out_is_last !== want.last) begin
                        $error("is_last: expected %0b, got %0b", want.last, i_out_is_last);
                        error_total++;
                    end
                    if (i_out_char_count !== want.count) begin
                        $error("char_count: expected %0d, got %0d",
                               want.count, i_out_char_count);
                        error_total++;
                    end
                end
            end
        end
        pending_chars <= expected_text.size();
    end

endmodule

@@ test/tb_integer_to_ascii_formatter.sv @@
// Top of the integer-to-ASCII formatter testbench: clock, reset, item stimulus and receiver
// stalls; ita_text_checker does the prediction and comparison.
// Depends on ita_pkg, ita_in_if/ita_out_if, the formatter RTL and ita_text_checker.
module tb_integer_to_ascii_formatter
    import ita_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS    = 120;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_LIMIT      = 3000;
    localparam int DRAIN_CYCLES    = 100;

    typedef enum int {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic i_clk;
    logic i_rst_n;

    ita_in_if  in_ch();
    ita_out_if out_ch();

    int error_count;
    int pending_chars;
    int chars_checked;
    int items_accepted = 0;
    int items_ignored  = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;

    integer_to_ascii_formatter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ita_text_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_ch.valid),
        .i_in_ready       (in_ch.ready),
        .i_in_value       (in_ch.value),
        .i_in_req_type    (in_ch.req_type),
        .i_out_valid      (out_ch.valid),
        .i_out_ready      (out_ch.ready),
        .i_out_char       (out_ch.char_out),
        .i_out_is_last    (out_ch.is_last),
        .i_out_char_count (out_ch.char_count),
        .o_error_count    (error_count),
        .o_pending        (pending_chars),
        .o_chars_checked  (chars_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offer one item and hold it until the transfer; open a random gap between bursts.
    task automatic offer_item(input logic [63:0] value, input logic [2:0] fmt);
        int gap;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid    <= 1'b1;
        in_ch.value    <= value;
        in_ch.req_type <= fmt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (fmt > FMT_PTR) begin
            items_ignored++;
        end else begin
            items_accepted++;
        end
    endtask

    initial begin
        logic [63:0] value;
        logic [2:0]  fmt;
        int          formatted;

        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.value    <= '0;
        in_ch.req_type <= FMT_SDEC;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // signed decimal: zero, one, minus one, most negative, most positive, high bits set
        offer_item(64'h0000_0000_0000_0000, FMT_SDEC);
        offer_item(64'h0000_0000_0000_0001, FMT_SDEC);
        offer_item(64'h0000_0000_FFFF_FFFF, FMT_SDEC);
        offer_item(64'h0000_0000_8000_0000, FMT_SDEC);
        offer_item(64'h0000_0000_7FFF_FFFF, FMT_SDEC);
        offer_item(64'hDEAD_BEEF_0000_007B, FMT_SDEC);
        offer_item(64'h0000_0000_0000_0000, FMT_UDEC);
        offer_item(64'hFFFF_FFFF_FFFF_FFFF, FMT_UDEC);
        offer_item(64'h0000_0000_3B9A_CA00, FMT_UDEC);
        offer_item(64'h0000_0000_0000_0000, FMT_HEXL);
        offer_item(64'h0000_0000_DEAD_BEEF, FMT_HEXL);
        offer_item(64'h1234_5678_ABCD_EF01, FMT_HEXL);
        offer_item(64'h0000_0000_0000_0000, FMT_HEXU);
        offer_item(64'h0000_0000_FFFF_FFFF, FMT_HEXU);
        offer_item(64'hFFFF_FFFF_0A1B_2C3D, FMT_HEXU);
        offer_item(64'h0000_0000_0000_0000, FMT_PTR);
        offer_item(64'hFFFF_FFFF_FFFF_FFFF, FMT_PTR);
        offer_item(64'h0000_0000_0000_0001, FMT_PTR);
        offer_item(64'h0000_7FFF_1234_ABCD, FMT_PTR);
        offer_item(64'hFFFF_FFFF_FFFF_FFFF, 3'd5);
        offer_item(64'h0000_0000_0000_0000, 3'd6);
        offer_item(64'hA5A5_A5A5_5A5A_5A5A, 3'd7);

        formatted = 0;
        while (formatted < RANDOM_ITEMS) begin
            value = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: value = '0;
                1: value = '1;
                2: value = value >> $urandom_range(1, 63);
                3: value[31:0] = 32'h8000_0000 | (value[31:0] >> $urandom_range(1, 31));
                4: value = value >> $urandom_range(50, 63);
                default: begin
                end
            endcase
            if ($urandom_range(0, 15) == 0) begin
                fmt = 3'($urandom_range(5, 7));
            end else begin
                fmt = 3'($urandom_range(0, 4));
                formatted++;
            end
            offer_item(value, fmt);
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_chars != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Formatted %0d items in all five formats (%0d with unused selectors dropped),",
                 items_accepted, items_ignored);
        $display("checked %0d characters under random sender gaps and receiver stalls.",
                 chars_checked);
        if (error_count == 0 && pending_chars == 0) begin
            $display("[integer_to_ascii_formatter] OK");
        end else begin
            $display("[integer_to_ascii_formatter] ERROR");
        end
        $finish;
    end

    // Receiver: switch between stall patterns, with one long hold-off while the sender keeps offering items.
    initial begin
        rx_mode_t mode;
        int       span;
        bit       held_off;
        mode     = RX_STREAM;
        span     = 0;
        held_off = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_off && items_accepted >= 40) begin
                held_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                if (span == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(30, 150);
                end
                span--;
                case (mode)
                    RX_STREAM:   out_ch.ready <= 1'b1;
                    RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 4) == 0);
                    RX_PERIODIC: out_ch.ready <= span[2];
                    default:     out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Stop the run once nothing has moved on either channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("[integer_to_ascii_formatter] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

@@ files.f @@
rtl/core/ita_pkg.sv
rtl/core/ita_if.sv
rtl/core/ita_cell.sv
rtl/core/ita_chain.sv
rtl/core/integer_to_ascii_formatter.sv
test/ita_text_checker.sv
test/tb_integer_to_ascii_formatter.sv
